/* rtl/wma_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wma_pkg
// Shared constants and controller/datapath interface types for the
// windowed moving average block.
// ----------------------------------------------------------------------------
package wma_pkg;

    localparam int SAMPLE_W  = 32;
    localparam int WIN_CFG_W = 8;

    typedef struct packed {
        logic load;       // accept input transaction
        logic acc_run;    // walk history and accumulate
        logic div_start;  // load divider from accumulator
        logic div_run;    // one divider step
        logic out_load;   // capture quotient into output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic acc_busy;
        logic div_done;
        logic out_full;
    } ctrl_sts_t;

endpackage
`default_nettype wire

/* rtl/wma_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wma_ctrl
// Sequencer: accept, accumulate window, divide, hand result to output.
// ----------------------------------------------------------------------------
module wma_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic               m_tready,
    input  wire wma_pkg::ctrl_sts_t sts,
    output wma_pkg::ctrl_cmd_t      cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        s_tready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                cmd.acc_run = 1'b1;
                if (!sts.acc_busy) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_run = 1'b1;
                if (sts.div_done && (!sts.out_full || m_tready)) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/wma_dpath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wma_dpath
// Sample history, window accumulator, restoring divider and output register.
// ----------------------------------------------------------------------------
module wma_dpath #(
    parameter int MAX_WINDOW = 128
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire wma_pkg::ctrl_cmd_t               cmd,
    output wma_pkg::ctrl_sts_t                    sts,
    input  wire logic                             cfg_wr_en,
    input  wire logic [wma_pkg::WIN_CFG_W-1:0]    cfg_wr_data,
    input  wire logic [wma_pkg::SAMPLE_W-1:0]     s_sample,
    input  wire logic                             s_last,
    output logic [wma_pkg::SAMPLE_W-1:0]          m_average,
    output logic                                  m_last,
    output logic                                  m_valid,
    input  wire logic                             m_ready
);

    localparam int SW  = wma_pkg::SAMPLE_W;
    localparam int AW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW  = $clog2(MAX_WINDOW + 1);
    localparam int SUW = SW + CW;
    localparam int DCW = $clog2(SUW + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_WINDOW - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(MAX_WINDOW);

    logic [SW-1:0]  hist_mem [MAX_WINDOW];
    logic [SW-1:0]  mem_q_reg;

    logic [wma_pkg::WIN_CFG_W-1:0] win_reg;
    logic [AW-1:0]  wr_slot_reg, wr_slot_next;
    logic [CW-1:0]  fill_reg, fill_next;
    logic [AW-1:0]  rd_idx_reg, rd_idx_next;
    logic [CW-1:0]  rem_reg, rem_next;
    logic           rd_pend_reg, rd_pend_next;
    logic [CW-1:0]  n_reg, n_next;
    logic           last_reg;
    logic signed [SUW-1:0] acc_reg, acc_next;

    logic [SUW-1:0] quo_reg, quo_next;
    logic [CW-1:0]  prem_reg, prem_next;
    logic           neg_reg, neg_next;
    logic [DCW-1:0] dcnt_reg, dcnt_next;

    logic [SW-1:0]  avg_reg, avg_next;
    logic           olast_reg;
    logic           oval_reg, oval_next;

    int             w_int;
    logic [CW-1:0]  w_eff;
    logic [CW-1:0]  fill_inc;
    logic           rd_issue;
    logic [CW:0]    shifted;
    logic [CW:0]    trial;
    logic [SW-1:0]  quo_lo;

    always_comb begin
        if (win_reg == '0) begin
            w_int = 1;
        end else if (int'(win_reg) > MAX_WINDOW) begin
            w_int = MAX_WINDOW;
        end else begin
            w_int = int'(win_reg);
        end
        w_eff    = CW'(w_int);
        fill_inc = (fill_reg == FULL_CNT) ? FULL_CNT : fill_reg + CW'(1);
        rd_issue = cmd.acc_run && (rem_reg != '0);

        wr_slot_next = wr_slot_reg;
        fill_next    = fill_reg;
        rd_idx_next  = rd_idx_reg;
        rem_next     = rem_reg;
        n_next       = n_reg;
        acc_next     = acc_reg;
        rd_pend_next = rd_issue;

        if (cmd.load) begin
            n_next   = (fill_inc < w_eff) ? fill_inc : w_eff;
            rem_next = n_next - CW'(1);
            acc_next = {{CW{s_sample[SW-1]}}, s_sample};
            rd_idx_next = (wr_slot_reg == '0) ? LAST_SLOT : wr_slot_reg - AW'(1);
            if (s_last) begin
                wr_slot_next = '0;
                fill_next    = '0;
            end else begin
                wr_slot_next = (wr_slot_reg == LAST_SLOT) ? '0 : wr_slot_reg + AW'(1);
                fill_next    = fill_inc;
            end
        end else begin
            if (rd_issue) begin
                rem_next    = rem_reg - CW'(1);
                rd_idx_next = (rd_idx_reg == '0) ? LAST_SLOT : rd_idx_reg - AW'(1);
            end
            if (rd_pend_reg) begin
                acc_next = acc_reg + {{CW{mem_q_reg[SW-1]}}, mem_q_reg};
            end
        end
    end

    // restoring divider, one quotient bit per cycle
    always_comb begin
        quo_next  = quo_reg;
        prem_next = prem_reg;
        neg_next  = neg_reg;
        dcnt_next = dcnt_reg;
        shifted   = {prem_reg, quo_reg[SUW-1]};
        trial     = shifted - {1'b0, n_reg};
        if (cmd.div_start) begin
            neg_next  = acc_reg[SUW-1];
            quo_next  = acc_reg[SUW-1] ? SUW'(-acc_reg) : SUW'(acc_reg);
            prem_next = '0;
            dcnt_next = DCW'(SUW);
        end else if (cmd.div_run && (dcnt_reg != '0)) begin
            dcnt_next = dcnt_reg - DCW'(1);
            if (shifted >= {1'b0, n_reg}) begin
                prem_next = trial[CW-1:0];
                quo_next  = {quo_reg[SUW-2:0], 1'b1};
            end else begin
                prem_next = shifted[CW-1:0];
                quo_next  = {quo_reg[SUW-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        quo_lo    = quo_reg[SW-1:0];
        avg_next  = neg_reg ? (~quo_lo + SW'(1)) : quo_lo;
        oval_next = cmd.out_load ? 1'b1 : (m_ready ? 1'b0 : oval_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            hist_mem[wr_slot_reg] <= s_sample;
        end
        if (rd_issue) begin
            mem_q_reg <= hist_mem[rd_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg     <= wma_pkg::WIN_CFG_W'(1);
            wr_slot_reg <= '0;
            fill_reg    <= '0;
            rem_reg     <= '0;
            rd_pend_reg <= 1'b0;
            dcnt_reg    <= '0;
            oval_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                win_reg <= cfg_wr_data;
            end
            wr_slot_reg <= wr_slot_next;
            fill_reg    <= fill_next;
            rem_reg     <= rem_next;
            rd_pend_reg <= rd_pend_next;
            dcnt_reg    <= dcnt_next;
            oval_reg    <= oval_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= rd_idx_next;
        n_reg      <= n_next;
        acc_reg    <= acc_next;
        quo_reg    <= quo_next;
        prem_reg   <= prem_next;
        neg_reg    <= neg_next;
        if (cmd.load) begin
            last_reg <= s_last;
        end
        if (cmd.out_load) begin
            avg_reg   <= avg_next;
            olast_reg <= last_reg;
        end
    end

    assign sts.acc_busy = (rem_reg != '0) || rd_pend_reg;
    assign sts.div_done = (dcnt_reg == '0);
    assign sts.out_full = oval_reg;

    assign m_average = avg_reg;
    assign m_last    = olast_reg;
    assign m_valid   = oval_reg;

endmodule
`default_nettype wire

/* rtl/windowed_moving_average.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_moving_average
// Moving average over the last window_size samples of a sequence.
// ----------------------------------------------------------------------------
// The history is read one entry per cycle and accumulated, then a restoring
// divider produces one quotient bit per cycle. One transaction is in progress
// at a time; the output register lets the next transaction be accepted while
// a result waits.
// Reset: synchronous active-low; window_size returns to 1, sequence restarts.
// ----------------------------------------------------------------------------
module windowed_moving_average #(
    parameter int MAX_WINDOW = 128
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,   // window_size
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,       // sample
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,       // average
    output logic             m_tlast
);

    wma_pkg::ctrl_cmd_t cmd;
    wma_pkg::ctrl_sts_t sts;

    wma_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wma_dpath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_sample    (s_tdata),
        .s_last      (s_tlast),
        .m_average   (m_tdata),
        .m_last      (m_tlast),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready)
    );

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transaction accepted while one is in progress");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("output register overwritten while held");

    a_div_after_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !sts.acc_busy)
        else $error("divider started before accumulation finished");

    a_load_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.div_done)
        else $error("result loaded before divider finished");

endmodule
`default_nettype wire
